@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AFT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define AFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/aft_pkg.sv @@
package aft_pkg;

  // field widths
  localparam int DELAY_W   = 20;
  localparam int ELAPSED_W = 16;
  localparam int CLAMP_W   = 10;
  localparam int CFG_W     = 9;
  localparam int QDEPTH    = 2;

  localparam logic [CLAMP_W-1:0] ELAPSED_CLAMP = 10'd1000;
  localparam logic [DELAY_W-1:0] DEFAULT_DELAY = 20'd100;
  localparam logic [DELAY_W-1:0] ACC_MAX       = 20'hFFFFF;

  // request opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [7:0]           entry_index;
    logic [DELAY_W-1:0]   delay_ms;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_index;
    logic       frame_changed;
  } out_item_t;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_TICK,
    CMD_RESTART
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         addr;
    logic [DELAY_W-1:0] delay;
    logic [CLAMP_W-1:0] elapsed;
  } cmd_t;

  // queue to back-end handshake
  typedef struct packed {
    logic valid;
    cmd_t head;
  } q_out_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_STEP,
    B_EMIT
  } bstate_t;

endpackage

@@ src/animation_frame_timer.sv @@
// Animated-image frame sequencer.
// Input channel (in_valid / in_stall / in_data) carries requests: load a
// frame delay into the table, a time tick with elapsed milliseconds, or a
// restart. Every request yields exactly one result on the output channel
// (out_valid / out_stall / out_data): the frame shown afterwards and whether
// the tick moved to another frame. cfg_we / cfg_wdata set the frame count;
// write it only while the block is idle.
// A load, restart, unused opcode, arming tick or tick on a static image is
// popped in idle and goes straight to the emit state; a timed tick first
// steps through the frames, at most the frame count of them, with one
// delay-table read per cycle. The back end takes a new request only once
// the result of the last one is in the output register.
// A two-entry command queue lets requests be accepted while the back end
// works or a result waits; in_stall rises only when that queue is full.
// When the receiver stalls, the result holds in the output register, the
// back end stops after the next finished request and the queue fills.
// Reset clears the frame index, accumulator, armed flag, frame count and
// all handshake state; the delay table is not cleared and must be loaded.
module animation_frame_timer import aft_pkg::*; #(
  parameter int MAX_FRAMES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

`include "assert_macros.svh"

  logic [CFG_W-1:0] frame_count_r;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  cmd_t             q_cmd;
  q_out_t           q_out;

  // frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  aft_front #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_front (
    .in_valid(in_valid),
    .in_data (in_data),
    .in_stall(in_stall),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  aft_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .q_out   (q_out)
  );

  aft_back #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_count(frame_count_r),
    .q_out      (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

  // queue and back-end consistency
  `AFT_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "push into full command queue")
  `AFT_ASSERT_IMPL(a_no_pop_empty, q_pop, q_out.valid, "pop from empty command queue")
  `AFT_ASSERT_NEXT(a_pop_spacing, q_pop, !q_pop, "back end popped twice in a row")

endmodule

@@ src/aft_front.sv @@
module aft_front import aft_pkg::*; #(
  parameter int MAX_FRAMES = 256
) (
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify the request, substitute default delay, clamp elapsed time
  always_comb begin
    q_cmd.addr    = in_data.entry_index;
    q_cmd.delay   = (in_data.delay_ms == '0) ? DEFAULT_DELAY : in_data.delay_ms;
    q_cmd.elapsed = (in_data.elapsed_ms > ELAPSED_W'(ELAPSED_CLAMP)) ?
                    ELAPSED_CLAMP : CLAMP_W'(in_data.elapsed_ms);
    case (in_data.op)
      OP_LOAD: begin
        // entries past the table are dropped
        q_cmd.kind = (32'(in_data.entry_index) < MAX_FRAMES) ? CMD_LOAD : CMD_NOP;
      end
      OP_TICK:    q_cmd.kind = CMD_TICK;
      OP_RESTART: q_cmd.kind = CMD_RESTART;
      default:    q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

@@ src/aft_queue.sv @@
module aft_queue import aft_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  cmd_t   push_cmd,
  input  logic   pop,
  output logic   full,
  output q_out_t q_out
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full        = (count_r == CW'(QDEPTH));
  assign q_out.valid = (count_r != '0);
  assign q_out.head  = slot_r[rd_ptr_r];

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/aft_back.sv @@
module aft_back import aft_pkg::*; #(
  parameter int MAX_FRAMES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] frame_count,
  input  q_out_t           q_out,
  output logic             q_pop,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             out_stall
);

  localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW   = $clog2(MAX_FRAMES + 1);
  localparam int CNTW = (NW > CFG_W) ? NW : CFG_W;

  bstate_t            state_r, state_nxt;
  logic [FW-1:0]      frame_r, frame_nxt;
  logic [FW-1:0]      prev_r, prev_nxt;
  logic [DELAY_W-1:0] acc_r, acc_nxt;
  logic               seen_r, seen_nxt;
  logic [CNTW-1:0]    steps_r, steps_nxt;
  logic               changed_r, changed_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [DELAY_W-1:0] delay_mem [MAX_FRAMES];
  logic [DELAY_W-1:0] rd_data_r;
  logic [FW-1:0]      rd_addr;
  logic               mem_we;

  logic [CNTW-1:0]    n_eff;
  logic [CNTW-1:0]    frame_inc;
  logic [FW-1:0]      step_next;
  logic [DELAY_W:0]   acc_sum;
  logic               animated;
  logic               tick_run;
  logic               step_go;
  logic               slot_free;

  // effective frame count, bounded by the table
  assign n_eff = (CNTW'(frame_count) > CNTW'(MAX_FRAMES)) ?
                 CNTW'(MAX_FRAMES) : CNTW'(frame_count);
  assign animated = (n_eff > CNTW'(1));

  // request popped in idle that needs the advance loop
  assign tick_run = q_out.valid && (q_out.head.kind == CMD_TICK) && animated && seen_r;

  // one advance step: compare against the delay read last cycle
  assign frame_inc = CNTW'(frame_r) + CNTW'(1);
  assign step_next = (frame_inc >= n_eff) ? '0 : FW'(frame_inc);
  assign step_go   = (steps_r < n_eff) && (acc_r >= rd_data_r);

  // saturating accumulate of the clamped elapsed time
  assign acc_sum = {1'b0, acc_r} + (DELAY_W + 1)'(q_out.head.elapsed);

  // output register can take a result this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_out.valid) begin
          state_nxt = tick_run ? B_STEP : B_EMIT;
        end
      end
      B_STEP: begin
        if (!step_go) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    frame_nxt     = frame_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    seen_nxt      = seen_r;
    steps_nxt     = steps_r;
    changed_nxt   = changed_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = frame_r;
    case (state_r)
      B_IDLE: begin
        if (q_out.valid) begin
          q_pop       = 1'b1;
          changed_nxt = 1'b0;
          case (q_out.head.kind)
            CMD_LOAD: mem_we = 1'b1;
            CMD_TICK: begin
              if (animated) begin
                if (!seen_r) begin
                  seen_nxt = 1'b1;
                end else begin
                  acc_nxt   = acc_sum[DELAY_W] ? ACC_MAX : acc_sum[DELAY_W-1:0];
                  prev_nxt  = frame_r;
                  steps_nxt = '0;
                end
              end
            end
            CMD_RESTART: begin
              frame_nxt = '0;
              acc_nxt   = '0;
              seen_nxt  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      B_STEP: begin
        if (step_go) begin
          acc_nxt   = acc_r - rd_data_r;
          frame_nxt = step_next;
          steps_nxt = steps_r + CNTW'(1);
          rd_addr   = step_next;
        end else begin
          changed_nxt = (frame_r != prev_r);
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.frame_index   = 8'(frame_r);
          out_item_nxt.frame_changed = changed_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      frame_r     <= '0;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    changed_r  <= changed_nxt;
    out_item_r <= out_item_nxt;
  end

  // delay table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      delay_mem[FW'(q_out.head.addr)] <= q_out.head.delay;
    end
    rd_data_r <= delay_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
